@@ design/psm_pkg.sv @@
// Package for the positive sample median block.
// Holds the controller state type and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_MED_RD,
    ST_MED_WAIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic shift;
    logic place;
    logic med_read;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic keep;
    logic cnt_zero;
    logic gt;
    logic pos_one;
    logic last_reg;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ design/psm_in_if.sv @@
// Input channel of the positive sample median block: one sample item.
// Carries valid, ready, sample and last. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface psm_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

@@ design/psm_out_if.sv @@
// Result channel of the positive sample median block: one result item.
// Carries valid, ready, median, empty_res and overflow. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface psm_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] median;
  logic                           empty_res;
  logic                           overflow;

  modport source (output valid, output median, output empty_res, output overflow,
                  input ready);
  modport sink   (input valid, input median, input empty_res, input overflow,
                  output ready);
endinterface

`default_nettype wire

@@ design/psm_datapath.sv @@
// Datapath of the positive sample median block: sorted sample memory,
// insertion walk, fill count, drop flag and result register. Uses psm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psm_datapath #(
  parameter int MAX_SAMPLES  = 64,
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire psm_pkg::dp_cmd_t               cmd,
  output psm_pkg::dp_status_t                 status,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                           in_last,
  output logic signed [SAMPLE_WIDTH-1:0]      median,
  output logic                                empty_res,
  output logic                                overflow,
  output logic                                out_valid,
  input  wire logic                           out_ready
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic signed [SAMPLE_WIDTH-1:0] mem [MAX_SAMPLES];
  logic signed [SAMPLE_WIDTH-1:0] rd_data;
  logic signed [SAMPLE_WIDTH-1:0] s_reg;
  logic                           last_reg;
  logic [AW-1:0]                  pos;
  logic [CW-1:0]                  count;
  logic                           dropped;

  logic                           positive;
  logic                           room;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic signed [SAMPLE_WIDTH-1:0] wr_data;
  logic                           gt;
  logic                           out_free;

  assign positive = !in_sample[SAMPLE_WIDTH-1] && (|in_sample);
  assign room     = count < CW'(MAX_SAMPLES);
  assign gt       = rd_data > s_reg;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    status.keep     = positive && room;
    status.cnt_zero = count == '0;
    status.gt       = gt;
    status.pos_one  = pos == AW'(1);
    status.last_reg = last_reg;
    status.out_free = out_free;
  end

  // read port: previous neighbour during the walk, median index at the close
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.accept && positive && room && count != '0) begin
      rd_en   = 1'b1;
      rd_addr = AW'(count - CW'(1));
    end else if (cmd.shift && gt && pos != AW'(1)) begin
      rd_en   = 1'b1;
      rd_addr = pos - AW'(2);
    end else if (cmd.med_read) begin
      rd_en   = 1'b1;
      rd_addr = AW'(count >> 1);
    end
  end

  always_comb begin
    wr_en   = cmd.shift || cmd.place;
    wr_addr = pos;
    wr_data = (cmd.shift && gt) ? rd_data : s_reg;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_reg    <= in_sample;
      last_reg <= in_last;
      pos      <= AW'(count);
    end else if (cmd.shift && gt) begin
      pos <= pos - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.load_out) begin
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      if (cmd.accept && positive && !room) begin
        dropped <= 1'b1;
      end
      if ((cmd.shift && !gt) || cmd.place) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      median    <= (count == '0) ? '0 : rd_data;
      empty_res <= count == '0;
      overflow  <= dropped;
    end
  end

endmodule

`default_nettype wire

@@ design/psm_ctrl.sv @@
// Controller of the positive sample median block: sequences acceptance,
// the insertion walk and the median read. Uses psm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_last,
  output logic                     in_ready,
  input  wire psm_pkg::dp_status_t status,
  output psm_pkg::dp_cmd_t         cmd
);

  psm_pkg::state_t state;
  psm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      psm_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (status.keep) begin
            state_next = status.cnt_zero ? psm_pkg::ST_PLACE : psm_pkg::ST_SHIFT;
          end else if (in_last) begin
            state_next = psm_pkg::ST_MED_RD;
          end
        end
      end
      psm_pkg::ST_SHIFT: begin
        if (status.gt) begin
          if (status.pos_one) begin
            state_next = psm_pkg::ST_PLACE;
          end
        end else begin
          state_next = status.last_reg ? psm_pkg::ST_MED_RD : psm_pkg::ST_IDLE;
        end
      end
      psm_pkg::ST_PLACE: begin
        state_next = status.last_reg ? psm_pkg::ST_MED_RD : psm_pkg::ST_IDLE;
      end
      psm_pkg::ST_MED_RD: begin
        state_next = psm_pkg::ST_MED_WAIT;
      end
      psm_pkg::ST_MED_WAIT: begin
        if (status.out_free) begin
          state_next = psm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = state == psm_pkg::ST_IDLE;
    cmd.accept   = (state == psm_pkg::ST_IDLE) && in_valid;
    cmd.shift    = state == psm_pkg::ST_SHIFT;
    cmd.place    = state == psm_pkg::ST_PLACE;
    cmd.med_read = state == psm_pkg::ST_MED_RD;
    cmd.load_out = (state == psm_pkg::ST_MED_WAIT) && status.out_free;
  end

endmodule

`default_nettype wire

@@ design/positive_sample_median.sv @@
// Positive sample median: top level joining controller and datapath.
// Uses psm_pkg, psm_in_if, psm_out_if, psm_ctrl and psm_datapath.
//
// Usage: sample items arrive on the samples channel; the item with last set
// closes the set and its sample belongs to it. Only strictly positive samples
// are kept, in an ascending sorted memory of MAX_SAMPLES entries; further
// positive samples are dropped and flag overflow. For each closing item one
// result item leaves on the results channel: the kept sample at index
// count/2 (upper median), or zero with empty_res set for an empty set.
// Sequence: an item that is not kept is handled in the idle state alone. A kept
// item goes on through the insertion walk, whose length grows with the kept
// count and which moves one memory entry per cycle through the single read and
// write port. A closing item then passes the median read and wait states; the
// result is registered and is loaded when the wait state ends.
// The result register lets the next set's items be taken while a result
// waits; a closing item waits only while the earlier result is unread.
// Reset (synchronous, active high) clears the fill count, the drop flag,
// the controller and the result valid; memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positive_sample_median #(
  parameter int MAX_SAMPLES  = 64,
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  psm_in_if.sink    samples,
  psm_out_if.source results
);

  psm_pkg::dp_cmd_t    cmd;
  psm_pkg::dp_status_t status;

  psm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_last  (samples.last),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  psm_datapath #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_sample (samples.sample),
    .in_last   (samples.last),
    .median    (results.median),
    .empty_res (results.empty_res),
    .overflow  (results.overflow),
    .out_valid (results.valid),
    .out_ready (results.ready)
  );

endmodule

`default_nettype wire

@@ verif/positive_sample_median_checker.sv @@
// Checker for the positive sample median block: watches both channels,
// keeps its own sorted set and compares every result item with its prediction.
// Depends on psm_in_if and psm_out_if.
`timescale 1ns / 1ps

module positive_sample_median_checker #(
  parameter int MAX_SAMPLES  = 64,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  psm_in_if    samples,
  psm_out_if   results,
  output int   fails,
  output int   pending,
  output int   checked,
  output int   empties,
  output int   overflows
);

  typedef logic signed [SAMPLE_WIDTH-1:0] charge_t;

  typedef struct packed {
    charge_t median;
    logic    empty_res;
    logic    overflow;
  } median_res_t;

  charge_t       ladder [MAX_SAMPLES];
  int unsigned   kept_n = 0;
  logic          dropped = 1'b0;
  median_res_t   median_due [$];
  int            fail_n = 0;
  int            checked_n = 0;
  int            empty_n = 0;
  int            overflow_n = 0;

  // insertion into the ascending ladder; full ladder drops and flags
  function automatic void keep_charge(input charge_t s);
    int unsigned pos;
    if (kept_n >= MAX_SAMPLES) begin
      dropped = 1'b1;
      return;
    end
    pos = kept_n;
    while (pos > 0 && ladder[pos-1] > s) begin
      ladder[pos] = ladder[pos-1];
      pos--;
    end
    ladder[pos] = s;
    kept_n++;
  endfunction

  function automatic median_res_t close_set();
    median_res_t r;
    if (kept_n == 0) begin
      r.median    = '0;
      r.empty_res = 1'b1;
    end else begin
      r.median    = ladder[kept_n/2];
      r.empty_res = 1'b0;
    end
    r.overflow = dropped;
    kept_n  = 0;
    dropped = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    median_res_t want;
    median_res_t got;
    logic        bad;
    if (!rst) begin
      if (samples.valid && samples.ready) begin
        if (samples.sample > 0)
          keep_charge(samples.sample);
        if (samples.last)
          median_due = {median_due, close_set()};
      end
      if (results.valid && results.ready) begin
        got.median    = results.median;
        got.empty_res = results.empty_res;
        got.overflow  = results.overflow;
        if (median_due.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("%0t: result item with none pending: median %0d empty %0b overflow %0b",
                     $realtime, got.median, got.empty_res, got.overflow);
        end else begin
          want = median_due.pop_front();
          checked_n++;
          if (want.empty_res)
            empty_n++;
          if (want.overflow)
            overflow_n++;
          bad = (got.median !== want.median) || (got.empty_res !== want.empty_res) ||
                (got.overflow !== want.overflow);
          if (bad) begin
            fail_n++;
            if (fail_n <= 10)
              $display("%0t: mismatch: expected median %0d empty %0b overflow %0b, got %0d %0b %0b",
                       $realtime, want.median, want.empty_res, want.overflow,
                       got.median, got.empty_res, got.overflow);
          end
        end
      end
    end
    fails     <= fail_n;
    pending   <= median_due.size();
    checked   <= checked_n;
    empties   <= empty_n;
    overflows <= overflow_n;
  end

endmodule

@@ verif/positive_sample_median_tb.sv @@
// Testbench top for the positive sample median block: clock, reset, sample
// stimulus, result back-pressure and the verdict.
// Depends on psm_in_if, psm_out_if, positive_sample_median and its checker.
`timescale 1ns / 1ps

module positive_sample_median_tb;

  localparam int MAX_SAMPLES  = 64;
  localparam int SAMPLE_WIDTH = 24;
  localparam int ITEM_TARGET  = 1650;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 100000;

  typedef logic signed [SAMPLE_WIDTH-1:0] charge_t;

  localparam charge_t MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam charge_t MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic clk;
  logic rst;

  psm_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) samples ();
  psm_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) results ();

  int   fails;
  int   pending;
  int   checked;
  int   empties;
  int   overflows;
  int   items_sent = 0;
  int   sets_sent = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;

  positive_sample_median #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples.sink),
    .results(results.source)
  );

  positive_sample_median_checker #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) median_check (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .results  (results),
    .fails    (fails),
    .pending  (pending),
    .checked  (checked),
    .empties  (empties),
    .overflows(overflows)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("positive_sample_median_tb NOT OK");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic charge_t rand_charge(input int pos_pct);
    logic [31:0] bits;
    int          r;
    bits = $urandom();
    if ($urandom_range(99) >= pos_pct) begin
      r = $urandom_range(99);
      if (r < 40)
        return '0;
      if (r < 50)
        return MOST_NEG;
      return {1'b1, bits[SAMPLE_WIDTH-2:0]};
    end
    r = $urandom_range(99);
    if (r < 30)
      return charge_t'($urandom_range(16, 1));
    if (r < 45)
      return $urandom_range(1) ? MOST_POS : charge_t'(1);
    return charge_t'($urandom_range(MOST_POS, 1));
  endfunction

  task automatic send_item(input charge_t s, input logic closes);
    while ($urandom_range(99) < send_idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid  <= 1'b1;
    samples.sample <= s;
    samples.last   <= closes;
    @(posedge clk);
    while (!samples.ready)
      @(posedge clk);
    items_sent++;
    if (closes)
      sets_sent++;
  endtask

  task automatic send_set(input int len, input int pos_pct);
    for (int i = 0; i < len; i++)
      send_item(rand_charge(pos_pct), i == len - 1);
  endtask

  task automatic send_random_set();
    int r;
    r = $urandom_range(99);
    if (r < 5)
      send_set($urandom_range(80, 62), 95);
    else if (r < 20)
      send_set($urandom_range(40, 13), 75);
    else if (r < 27)
      send_set($urandom_range(4, 1), 0);
    else
      send_set($urandom_range(12, 1), 75);
  endtask

  // sender pauses until every predicted result has left the block or DRAIN_LIMIT is reached
  task automatic wait_drained();
    int waited;
    waited = 0;
    samples.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  initial begin : stimulus
    int span;
    int phase_end;
    rst            <= 1'b1;
    samples.valid  <= 1'b0;
    samples.sample <= '0;
    samples.last   <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty sets, lone extremes, upper median, closing on a non-positive item
    send_item('0, 1'b1);
    send_item(MOST_NEG, 1'b1);
    send_item(MOST_POS, 1'b1);
    send_item(charge_t'(1), 1'b1);
    send_item(charge_t'(5), 1'b0);
    send_item(charge_t'(3), 1'b1);
    send_item(charge_t'(7), 1'b0);
    send_item(charge_t'(-1), 1'b0);
    send_item('0, 1'b1);
    send_item(charge_t'(10), 1'b0);
    send_item(charge_t'(2), 1'b0);
    send_item(charge_t'(8), 1'b1);
    send_item(charge_t'(4), 1'b0);
    send_item(charge_t'(4), 1'b0);
    send_item(charge_t'(9), 1'b0);
    send_item(charge_t'(4), 1'b1);
    send_item(charge_t'(-5), 1'b0);
    send_item('0, 1'b0);
    send_item(MOST_NEG, 1'b1);
    send_item(MOST_POS, 1'b0);
    send_item(charge_t'(1), 1'b0);
    send_item(MOST_POS, 1'b0);
    send_item(charge_t'(1), 1'b1);
    wait_drained();

    span = (ITEM_TARGET - items_sent) / 4;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 88;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 88;
        end
        default: begin
          send_idle_pct = 28;
          stall_pct <= 28;
        end
      endcase
      phase_end = (ph == 3) ? ITEM_TARGET : items_sent + span;
      if (ph == 0)
        send_set(70, 100);
      while (items_sent < phase_end)
        send_random_set();
      if (ph == 0) begin
        // results held back while short sets keep coming: input must stall
        hold_req <= ~hold_req;
        for (int k = 0; k < 6; k++)
          send_set($urandom_range(5, 1), 75);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d sample items in %0d sets over four idle/stall phases and a %0d-cycle result hold-off",
             items_sent, sets_sent, HOLD_CYCLES);
    $display("%0d medians checked, %0d empty sets, %0d overflowed sets, %0d failures, %0d outstanding",
             checked, empties, overflows, fails, pending);
    if (fails == 0 && pending == 0) begin
      $display("positive_sample_median_tb OK");
    end else begin
      $display("positive_sample_median_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/psm_pkg.sv
design/psm_in_if.sv
design/psm_out_if.sv
design/psm_datapath.sv
design/psm_ctrl.sv
design/positive_sample_median.sv
verif/positive_sample_median_checker.sv
verif/positive_sample_median_tb.sv
